### sv/gses_pkg.sv
// Shared types and constants for the six-neighbor stencil pass.
`default_nettype none

package gses_pkg;

  // Default sizing of the top level.
  localparam int MAX_X_DEF      = 64;
  localparam int MAX_Y_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Largest grid extent along z.
  localparam int LIMIT_Z = 1024;

  // Quotient bits produced per cycle by the averaging divider.
  localparam int DIV_K = 8;

  // Configuration port.
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SIZE_X = 2'd1;
  localparam logic [1:0] REG_SIZE_Y = 2'd2;
  localparam logic [1:0] REG_SIZE_Z = 2'd3;

  localparam logic       MODE_RST   = 1'b0;
  localparam logic [6:0] SIZE_X_RST = 7'd64;
  localparam logic [6:0] SIZE_Y_RST = 7'd64;
  localparam logic [10:0] SIZE_Z_RST = 11'd64;

  localparam logic MODE_SMOOTH = 1'b1;
  localparam logic CMD_PUSH    = 1'b0;

  // Window reads issued for one output cell, in this order.
  localparam logic [2:0] SLOT_CENTER = 3'd0;
  localparam logic [2:0] SLOT_XLO    = 3'd1;
  localparam logic [2:0] SLOT_XHI    = 3'd2;
  localparam logic [2:0] SLOT_YLO    = 3'd3;
  localparam logic [2:0] SLOT_YHI    = 3'd4;
  localparam logic [2:0] SLOT_ZLO    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_DIV,
    ST_RES,
    ST_OUT,
    ST_WRITE
  } state_e;

endpackage

`default_nettype wire

### sv/grid_stencil_extrapolate_smooth.sv
// Six-neighbor 3D stencil pass with extrapolate and smooth modes over a two-plane window memory.
//
// Channel  Kind    Payload                                    Transfer at
// in       input   cmd_i, cell_value_i, cell_valid_i          in_valid_i & in_ready_o
// out      output  new_value_o, new_valid_o, last_cell_o      out_valid_o & out_ready_i
// config   APB     paddr, pwdata, prdata                      psel & penable & pwrite & pready
//
// One item at a time. A push that emits nothing only writes its cell to the window; a flush
// with nothing to emit is simply taken. An item that emits a cell reads the window, computes and
// outputs, dividing when an average is taken; a push then writes its cell. The time is set by the six
// reads of the single-port window memory and the divider, which retires 8 quotient bits a cycle.
// Reset clears only control state; the window memory is not cleared and needs no sweep.
// A finished cell waits in the output register; the block holds in its output step while full.
`default_nettype none

module grid_stencil_extrapolate_smooth
  import gses_pkg::*;
#(
  parameter int MAX_X      = MAX_X_DEF,
  parameter int MAX_Y      = MAX_Y_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Cell input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic signed [31:0]  cell_value_i,
  input  logic                cell_valid_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  new_value_o,
  output logic                new_valid_o,
  output logic                last_cell_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int XW      = $clog2(MAX_X);
  localparam int SXW     = $clog2(MAX_X + 1);
  localparam int YW      = $clog2(MAX_Y);
  localparam int SYW     = $clog2(MAX_Y + 1);
  localparam int ZW      = $clog2(LIMIT_Z);
  localparam int SZW     = $clog2(LIMIT_Z + 1);
  localparam int DEPTH   = 2 * MAX_X * MAX_Y;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = VALUE_BITS + 3;
  localparam int DIV_CYC = (SW + DIV_K - 1) / DIV_K;
  localparam int DIV_W   = DIV_CYC * DIV_K;
  localparam int DCW     = $clog2(DIV_CYC);

  // Ring arithmetic on window addresses; offsets are always below DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, a} - {1'b0, off};
    if (s[AW]) begin
      s = s + (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Control state.
  state_e           state_q, state_d;
  logic [2:0]       rs_q, rs_d;
  logic             rv_q, rv_d;
  logic [2:0]       rslot_q, rslot_d;
  logic [DCW-1:0]   dcnt_q, dcnt_d;
  logic             out_valid_q, out_valid_d;
  logic [XW-1:0]    ex_q, ex_d, rx_q, rx_d;
  logic [YW-1:0]    ey_q, ey_d, ry_q, ry_d;
  logic [ZW-1:0]    ez_q, ez_d, rz_q, rz_d;
  logic             recv_all_q, recv_all_d;
  logic [AW-1:0]    wa_q, wa_d, ea_q, ea_d, pa_q, pa_d;
  logic             mode_q, mode_d;
  logic [6:0]       size_x_q, size_x_d, size_y_q, size_y_d;
  logic [10:0]      size_z_q, size_z_d;

  // Payload state.
  logic                          have_inc_q, have_inc_d;
  logic signed [VALUE_BITS-1:0]  inc_val_q, inc_val_d;
  logic                          inc_ok_q, inc_ok_d;
  logic signed [SW-1:0]          sum_q, sum_d, sumok_q, sumok_d;
  logic [2:0]                    cnt_q, cnt_d, cntok_q, cntok_d;
  logic signed [VALUE_BITS-1:0]  cv_q, cv_d;
  logic                          cok_q, cok_d;
  logic                          use_min_q, use_min_d;
  logic                          res_ok_q, res_ok_d;
  logic                          neg_q, neg_d;
  logic [2:0]                    den_q, den_d;
  logic [DIV_W-1:0]              dq_q, dq_d;
  logic [2:0]                    rem_q, rem_d;
  logic signed [VALUE_BITS-1:0]  res_q, res_d;
  logic [31:0]                   out_value_q, out_value_d;
  logic                          out_ok_q, out_ok_d;
  logic                          out_last_q, out_last_d;

  // Window memory.
  logic [VALUE_BITS:0] store_q [DEPTH];
  logic [VALUE_BITS:0] rdata_q;
  logic                mem_re, mem_we;
  logic [AW-1:0]       raddr;

  // Derived signals.
  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [SZW-1:0] sz;
  logic ex_hi, ey_hi, ez_hi, rx_hi, ry_hi, rz_hi, last_emit;
  logic accept, push_ok, emit_now, out_free, cfg_we;
  logic signed [63:0] in_ext;
  logic signed [VALUE_BITS-1:0] in_val;
  logic signed [VALUE_BITS-1:0] rd_val;
  logic rd_ok, nb_in;
  logic div_go, calc_min, calc_ok;
  logic signed [SW-1:0] calc_num;
  logic [2:0] calc_den;
  logic [SW-1:0] calc_mag;
  logic [DIV_W-1:0] dq_t;
  logic [3:0] r_t;
  logic [VALUE_BITS-1:0] quo;
  logic signed [VALUE_BITS-1:0] avg;
  logic signed [63:0] res_ext;

  // Sizes as used by the pass: zero means one, large values stop at the maximum.
  always_comb begin
    if (size_x_q == '0) begin
      sx = SXW'(1);
    end else if (32'(size_x_q) > MAX_X) begin
      sx = SXW'(MAX_X);
    end else begin
      sx = SXW'(size_x_q);
    end
    if (size_y_q == '0) begin
      sy = SYW'(1);
    end else if (32'(size_y_q) > MAX_Y) begin
      sy = SYW'(MAX_Y);
    end else begin
      sy = SYW'(size_y_q);
    end
    if (size_z_q == '0) begin
      sz = SZW'(1);
    end else if (32'(size_z_q) > LIMIT_Z) begin
      sz = SZW'(LIMIT_Z);
    end else begin
      sz = SZW'(size_z_q);
    end
  end

  assign ex_hi = (SXW'(ex_q) == sx - SXW'(1));
  assign ey_hi = (SYW'(ey_q) == sy - SYW'(1));
  assign ez_hi = (SZW'(ez_q) == sz - SZW'(1));
  assign rx_hi = (SXW'(rx_q) == sx - SXW'(1));
  assign ry_hi = (SYW'(ry_q) == sy - SYW'(1));
  assign rz_hi = (SZW'(rz_q) == sz - SZW'(1));
  assign last_emit = ex_hi && ey_hi && ez_hi;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push_ok    = (cmd_i == CMD_PUSH) && !recv_all_q;
  // A push emits once the first plane is in; anything else emits only while draining.
  assign emit_now   = push_ok ? (rz_q != '0) : recv_all_q;
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_ext = 64'(cell_value_i);
  assign in_val = in_ext[VALUE_BITS-1:0];

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = 32'(mode_q);
      REG_SIZE_X: prdata = 32'(size_x_q);
      REG_SIZE_Y: prdata = 32'(size_y_q);
      REG_SIZE_Z: prdata = 32'(size_z_q);
      default:    prdata = '0;
    endcase
  end

  // Window reads: the cell being finished and its stored neighbors.
  assign mem_re = (state_q == ST_READ);
  assign mem_we = (state_q == ST_WRITE);

  always_comb begin
    case (rs_q)
      SLOT_CENTER: raddr = ea_q;
      SLOT_XLO:    raddr = ring_sub(ea_q, AW'(1));
      SLOT_XHI:    raddr = ring_add(ea_q, AW'(1));
      SLOT_YLO:    raddr = ring_sub(ea_q, AW'(sx));
      SLOT_YHI:    raddr = ring_add(ea_q, AW'(sx));
      default:     raddr = pa_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[wa_q] <= {inc_ok_q, inc_val_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= store_q[raddr];
    end
  end

  assign rd_val = rdata_q[VALUE_BITS-1:0];
  assign rd_ok  = rdata_q[VALUE_BITS];

  always_comb begin
    case (rslot_q)
      SLOT_XLO: nb_in = (ex_q != '0);
      SLOT_XHI: nb_in = !ex_hi;
      SLOT_YLO: nb_in = (ey_q != '0);
      SLOT_YHI: nb_in = !ey_hi;
      SLOT_ZLO: nb_in = (ez_q != '0);
      default:  nb_in = 1'b0;
    endcase
  end

  // Choice between the plain and the valid-only average.
  always_comb begin
    if (mode_q == MODE_SMOOTH) begin
      div_go   = (cnt_q != '0);
      calc_num = sum_q;
      calc_den = cnt_q;
      calc_min = 1'b1;
      calc_ok  = cok_q;
    end else begin
      div_go   = !cok_q && (cntok_q != '0);
      calc_num = sumok_q;
      calc_den = cntok_q;
      calc_min = 1'b0;
      calc_ok  = cok_q || (cntok_q != '0);
    end
    calc_mag = calc_num[SW-1] ? SW'(-calc_num) : SW'(calc_num);
  end

  // Restoring division by a count of one to six, DIV_K quotient bits per cycle.
  always_comb begin
    dq_t = dq_q;
    r_t  = {1'b0, rem_q};
    for (int i = 0; i < DIV_K; i++) begin
      r_t  = {r_t[2:0], dq_t[DIV_W-1]};
      dq_t = {dq_t[DIV_W-2:0], 1'b0};
      if (r_t >= {1'b0, den_q}) begin
        r_t     = r_t - {1'b0, den_q};
        dq_t[0] = 1'b1;
      end
    end
  end

  assign quo     = dq_q[VALUE_BITS-1:0];
  assign avg     = neg_q ? (VALUE_BITS'(0) - quo) : quo;
  assign res_ext = 64'(res_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (emit_now) begin
            state_d = ST_READ;
          end else if (push_ok) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_READ: begin
        if (rs_q == SLOT_ZLO) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: state_d = ST_CALC;
      ST_CALC: state_d = div_go ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (dcnt_q == DCW'(DIV_CYC - 1)) begin
          state_d = ST_RES;
        end
      end
      ST_RES: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = have_inc_q ? ST_WRITE : ST_IDLE;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and counters.
  always_comb begin
    rs_d        = rs_q;
    rv_d        = mem_re;
    rslot_d     = rs_q;
    dcnt_d      = dcnt_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    ez_d        = ez_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    rz_d        = rz_q;
    recv_all_d  = recv_all_q;
    wa_d        = wa_q;
    ea_d        = ea_q;
    pa_d        = pa_q;
    mode_d      = mode_q;
    size_x_d    = size_x_q;
    size_y_d    = size_y_q;
    size_z_d    = size_z_q;
    have_inc_d  = have_inc_q;
    inc_val_d   = inc_val_q;
    inc_ok_d    = inc_ok_q;
    sum_d       = sum_q;
    sumok_d     = sumok_q;
    cnt_d       = cnt_q;
    cntok_d     = cntok_q;
    cv_d        = cv_q;
    cok_d       = cok_q;
    use_min_d   = use_min_q;
    res_ok_d    = res_ok_q;
    neg_d       = neg_q;
    den_d       = den_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    res_d       = res_q;
    out_value_d = out_value_q;
    out_ok_d    = out_ok_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    // The incoming cell is the z+1 neighbor of the cell it releases.
    if (accept) begin
      have_inc_d = push_ok;
      inc_val_d  = in_val;
      inc_ok_d   = cell_valid_i;
      rs_d       = SLOT_CENTER;
      sum_d      = '0;
      sumok_d    = '0;
      cnt_d      = '0;
      cntok_d    = '0;
      if (push_ok && !ez_hi) begin
        sum_d = SW'(in_val);
        cnt_d = 3'd1;
        if (cell_valid_i) begin
          sumok_d = SW'(in_val);
          cntok_d = 3'd1;
        end
      end
    end

    if (state_q == ST_READ) begin
      rs_d = rs_q + 3'd1;
    end

    if (rv_q) begin
      if (rslot_q == SLOT_CENTER) begin
        cv_d  = rd_val;
        cok_d = rd_ok;
      end else if (nb_in) begin
        sum_d = sum_q + SW'(rd_val);
        cnt_d = cnt_q + 3'd1;
        if (rd_ok) begin
          sumok_d = sumok_q + SW'(rd_val);
          cntok_d = cntok_q + 3'd1;
        end
      end
    end

    if (state_q == ST_CALC) begin
      use_min_d = calc_min;
      res_ok_d  = calc_ok;
      res_d     = cv_q;
      neg_d     = calc_num[SW-1];
      den_d     = calc_den;
      dq_d      = DIV_W'(calc_mag);
      rem_d     = '0;
      dcnt_d    = '0;
    end

    if (state_q == ST_DIV) begin
      dq_d   = dq_t;
      rem_d  = r_t[2:0];
      dcnt_d = dcnt_q + DCW'(1);
    end

    if (state_q == ST_RES) begin
      res_d = (use_min_q && !(avg < cv_q)) ? cv_q : avg;
    end

    if (state_q == ST_OUT && out_free) begin
      out_valid_d = 1'b1;
      out_value_d = res_ext[31:0];
      out_ok_d    = res_ok_q;
      out_last_d  = last_emit;
      ea_d        = ring_add(ea_q, AW'(1));
      if (ez_q != '0) begin
        pa_d = ring_add(pa_q, AW'(1));
      end
      if (ex_hi) begin
        ex_d = '0;
        if (ey_hi) begin
          ey_d = '0;
          ez_d = ez_q + ZW'(1);
        end else begin
          ey_d = ey_q + YW'(1);
        end
      end else begin
        ex_d = ex_q + XW'(1);
      end
      // The final cell ends the pass; the next push starts a new one.
      if (last_emit) begin
        ex_d       = '0;
        ey_d       = '0;
        ez_d       = '0;
        rx_d       = '0;
        ry_d       = '0;
        rz_d       = '0;
        recv_all_d = 1'b0;
        wa_d       = '0;
        ea_d       = '0;
        pa_d       = '0;
      end
    end

    if (state_q == ST_WRITE) begin
      wa_d = ring_add(wa_q, AW'(1));
      if (rx_hi) begin
        rx_d = '0;
        if (ry_hi) begin
          ry_d = '0;
          if (rz_hi) begin
            rz_d       = '0;
            recv_all_d = 1'b1;
          end else begin
            rz_d = rz_q + ZW'(1);
          end
        end else begin
          ry_d = ry_q + YW'(1);
        end
      end else begin
        rx_d = rx_q + XW'(1);
      end
    end

    // Any register write restarts the pass.
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_MODE:   mode_d   = pwdata[0];
        REG_SIZE_X: size_x_d = pwdata[6:0];
        REG_SIZE_Y: size_y_d = pwdata[6:0];
        REG_SIZE_Z: size_z_d = pwdata[10:0];
        default:    mode_d   = mode_q;
      endcase
      ex_d       = '0;
      ey_d       = '0;
      ez_d       = '0;
      rx_d       = '0;
      ry_d       = '0;
      rz_d       = '0;
      recv_all_d = 1'b0;
      wa_d       = '0;
      ea_d       = '0;
      pa_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rs_q        <= SLOT_CENTER;
      rv_q        <= 1'b0;
      rslot_q     <= SLOT_CENTER;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      ex_q        <= '0;
      ey_q        <= '0;
      ez_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      rz_q        <= '0;
      recv_all_q  <= 1'b0;
      wa_q        <= '0;
      ea_q        <= '0;
      pa_q        <= '0;
      mode_q      <= MODE_RST;
      size_x_q    <= SIZE_X_RST;
      size_y_q    <= SIZE_Y_RST;
      size_z_q    <= SIZE_Z_RST;
    end else begin
      state_q     <= state_d;
      rs_q        <= rs_d;
      rv_q        <= rv_d;
      rslot_q     <= rslot_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
      ex_q        <= ex_d;
      ey_q        <= ey_d;
      ez_q        <= ez_d;
      rx_q        <= rx_d;
      ry_q        <= ry_d;
      rz_q        <= rz_d;
      recv_all_q  <= recv_all_d;
      wa_q        <= wa_d;
      ea_q        <= ea_d;
      pa_q        <= pa_d;
      mode_q      <= mode_d;
      size_x_q    <= size_x_d;
      size_y_q    <= size_y_d;
      size_z_q    <= size_z_d;
    end
  end

  always_ff @(posedge clk_i) begin
    have_inc_q  <= have_inc_d;
    inc_val_q   <= inc_val_d;
    inc_ok_q    <= inc_ok_d;
    sum_q       <= sum_d;
    sumok_q     <= sumok_d;
    cnt_q       <= cnt_d;
    cntok_q     <= cntok_d;
    cv_q        <= cv_d;
    cok_q       <= cok_d;
    use_min_q   <= use_min_d;
    res_ok_q    <= res_ok_d;
    neg_q       <= neg_d;
    den_q       <= den_d;
    dq_q        <= dq_d;
    rem_q       <= rem_d;
    res_q       <= res_d;
    out_value_q <= out_value_d;
    out_ok_q    <= out_ok_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = out_value_q;
  assign new_valid_o = out_ok_q;
  assign last_cell_o = out_last_q;

  // The read-modify-write order keeps the window write apart from its reads.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("window memory read and written in the same cycle");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (cntok_q <= cnt_q))
    else $error("more valid neighbors than neighbors");

  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SXW'(ex_q) < sx) && (SYW'(ey_q) < sy) && (SZW'(ez_q) < sz) &&
    (SXW'(rx_q) < sx) && (SYW'(ry_q) < sy) && (SZW'(rz_q) < sz))
    else $error("cell coordinate outside the grid");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (den_q != '0))
    else $error("average taken over no neighbors");

endmodule

`default_nettype wire
